// ===== src/mep_pkg.sv =====
package mep_pkg;

	localparam int FRAC_BITS = 24;
	localparam int FIX_W = 32;
	localparam int WIDE_W = 40;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int LIMIT_W = 6;
	localparam int WIDTH_W = 6;
	localparam int HEIGHT_W = 7;
	localparam int COORD_W = 6;
	localparam int ITER_W = 6;
	localparam int ADDR_W = 9;
	localparam int BYTE_W = 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd49;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd48;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;

	// |z|^2 bound of 4.0 in Q8.24, one bit wider than the squared terms
	localparam logic signed [WIDE_W:0] ESC_BOUND = 41'sd67108864;

	typedef logic signed [FIX_W-1:0] fix_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ITER_LIMIT   = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RE,
		F_IM,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_MUL,
		B_ADD,
		B_READ,
		B_WRITE
	} back_state_t;

	typedef struct packed {
		logic                start;
		logic                neg;
		logic [HEIGHT_W-1:0] mag;
		logic [HEIGHT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		fix_t quot;
	} div_rsp_t;

	typedef struct packed {
		fix_t               c_re;
		fix_t               c_im;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} job_t;

	// (2*pos - span) split into sign and magnitude; span below 2 is used as 2
	function automatic div_req_t axis_req(input logic [COORD_W-1:0] pos,
	                                      input logic [HEIGHT_W-1:0] span);
		logic [HEIGHT_W-1:0] s;
		logic signed [HEIGHT_W:0] diff;
		div_req_t r;
		s = (span < 7'd2) ? 7'd2 : span;
		diff = $signed({1'b0, pos, 1'b0}) - $signed({1'b0, s});
		r.start = 1'b0;
		r.neg = diff[HEIGHT_W];
		r.mag = diff[HEIGHT_W] ? HEIGHT_W'(-diff) : diff[HEIGHT_W-1:0];
		r.divisor = s;
		return r;
	endfunction

endpackage

// ===== src/mep_pix_if.sv =====
interface mep_pix_if;
	import mep_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_row;
	logic [COORD_W-1:0] pixel_col;

	modport source (output valid, pixel_row, pixel_col, input ready);
	modport sink (input valid, pixel_row, pixel_col, output ready);

endinterface

// ===== src/mep_res_if.sv =====
interface mep_res_if;
	import mep_pkg::*;

	logic              valid;
	logic              ready;
	logic              inside_res;
	logic [ITER_W-1:0] iterations_done;
	logic [ADDR_W-1:0] byte_address;
	logic [BYTE_W-1:0] byte_value;

	modport source (output valid, inside_res, iterations_done, byte_address, byte_value,
		input ready);
	modport sink (input valid, inside_res, iterations_done, byte_address, byte_value,
		output ready);

endinterface

// ===== src/mep_cfg_if.sv =====
interface mep_cfg_if;
	import mep_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);

endinterface

// ===== src/mep_div.sv =====
module mep_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mep_pkg::div_req_t  req,
	output mep_pkg::div_rsp_t  rsp
);
	import mep_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [HEIGHT_W-1:0]  rem_q;
	logic [HEIGHT_W-1:0]  dvs_q;
	logic [FIX_W-1:0]     quo_q;
	logic                 neg_q;

	logic [HEIGHT_W:0]    trial;
	logic                 fits;
	logic [HEIGHT_W-1:0]  rem_nx;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[FIX_W-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign rem_nx = fits ? HEIGHT_W'(trial - {1'b0, dvs_q}) : trial[HEIGHT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			neg_q <= req.neg;
			quo_q <= {req.mag, {(FIX_W - HEIGHT_W){1'b0}}};
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[FIX_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? fix_t'(-quo_q) : fix_t'(quo_q);

endmodule

// ===== src/mep_front.sv =====
module mep_front (
	input  logic                           clk,
	input  logic                           arst_n,
	mep_pix_if.sink                        pix,
	input  logic                           clr_busy,
	input  logic [mep_pkg::WIDTH_W-1:0]    image_width,
	input  logic [mep_pkg::HEIGHT_W-1:0]   image_height,
	output logic                           push_valid,
	input  logic                           push_ready,
	output mep_pkg::job_t                  push_data
);
	import mep_pkg::*;

	front_state_t       state_q;
	front_state_t       state_nx;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	fix_t               c_re_q;
	fix_t               c_im_q;

	logic     take;
	div_req_t req;
	div_rsp_t rsp;

	mep_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			F_IDLE: if (take) state_nx = F_RE;
			F_RE:   if (rsp.done) state_nx = F_IM;
			F_IM:   if (rsp.done) state_nx = F_PUSH;
			F_PUSH: if (push_ready) state_nx = F_IDLE;
			default: state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		pix.ready = (state_q == F_IDLE) && !clr_busy;
		take = pix.valid && pix.ready;
		push_valid = (state_q == F_PUSH);
		if (state_q == F_IDLE) begin
			req = axis_req(pix.pixel_col, {1'b0, image_width});
			req.start = take;
		end else begin
			req = axis_req(row_q, image_height);
			req.start = (state_q == F_RE) && rsp.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_q <= pix.pixel_row;
			col_q <= pix.pixel_col;
		end
		if (state_q == F_RE && rsp.done) begin
			c_re_q <= rsp.quot;
		end
		if (state_q == F_IM && rsp.done) begin
			c_im_q <= rsp.quot;
		end
	end

	assign push_data.c_re = c_re_q;
	assign push_data.c_im = c_im_q;
	assign push_data.row = row_q;
	assign push_data.col = col_q;

endmodule

// ===== src/mep_queue.sv =====
module mep_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mep_pkg::job_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mep_pkg::job_t  pop_data
);
	import mep_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]       cnt_q;

	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/mep_back.sv =====
module mep_back #(
	parameter int DISPLAY_COLUMNS = 64,
	parameter int PAGE_COUNT = 6,
	parameter int MAX_ITERATIONS = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mep_pkg::LIMIT_W-1:0]  iteration_limit,
	input  logic                         job_valid,
	output logic                         job_ready,
	input  mep_pkg::job_t                job,
	output logic                         clr_busy,
	mep_res_if.source                    res
);
	import mep_pkg::*;

	localparam int STORE_BYTES = PAGE_COUNT * DISPLAY_COLUMNS;
	localparam int SAW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int FAW = $clog2(8 * DISPLAY_COLUMNS + 64);
	localparam int CW = $clog2(MAX_ITERATIONS + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

	back_state_t        state_q;
	back_state_t        state_nx;
	logic [SAW-1:0]     clr_q;
	fix_t               c_re_q;
	fix_t               c_im_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic [CW-1:0]      lim_q;
	logic [CW-1:0]      cnt_q;
	fix_t               x_q;
	fix_t               y_q;
	wide_t              xx_q;
	wide_t              yy_q;
	fix_t               xy_q;
	logic [BYTE_W-1:0]  rd_q;
	logic [BYTE_W-1:0]  mem [STORE_BYTES];

	logic                 res_valid_q;
	logic                 res_inside_q;
	logic [ITER_W-1:0]    res_iter_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic [BYTE_W-1:0]    res_byte_q;

	logic                 clr_last;
	logic                 limit_hit;
	logic                 escape;
	logic                 res_free;
	logic                 load_res;
	logic                 mem_we;
	logic                 mem_re;
	logic [CMPW-1:0]      lim_ext;
	logic [CMPW-1:0]      max_ext;
	logic [CMPW-1:0]      lim_cl;
	logic signed [2*FIX_W-1:0] p_xx;
	logic signed [2*FIX_W-1:0] p_yy;
	logic signed [2*FIX_W-1:0] p_xy;
	logic signed [WIDE_W:0]    mag2;
	logic [2:0]           page;
	logic                 in_store;
	logic [FAW-1:0]       addr;
	logic [SAW-1:0]       wr_addr;
	logic [BYTE_W-1:0]    wr_data;
	logic [BYTE_W-1:0]    bit_mask;
	logic [BYTE_W-1:0]    new_byte;

	assign clr_last = clr_q == SAW'(STORE_BYTES - 1);
	assign limit_hit = cnt_q >= lim_q;
	assign res_free = !res_valid_q || res.ready;

	assign lim_ext = CMPW'(iteration_limit);
	assign max_ext = CMPW'(MAX_ITERATIONS);
	assign lim_cl = (lim_ext > max_ext) ? max_ext : lim_ext;

	assign p_xx = x_q * x_q;
	assign p_yy = y_q * y_q;
	assign p_xy = x_q * y_q;
	assign mag2 = {xx_q[WIDE_W-1], xx_q} + {yy_q[WIDE_W-1], yy_q};
	assign escape = mag2 > ESC_BOUND;

	assign page = col_q[COORD_W-1:3];
	assign in_store = (32'(page) < PAGE_COUNT) && (32'(row_q) < DISPLAY_COLUMNS);
	assign addr = FAW'(page) * FAW'(DISPLAY_COLUMNS) + FAW'(row_q);
	assign bit_mask = BYTE_W'(1) << col_q[2:0];
	assign new_byte = limit_hit ? (rd_q | bit_mask) : (rd_q & ~bit_mask);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_last) state_nx = B_IDLE;
			B_IDLE:  if (job_valid) state_nx = B_MUL;
			B_MUL:   state_nx = limit_hit ? B_READ : B_ADD;
			B_ADD:   if (escape) state_nx = B_READ; else state_nx = B_MUL;
			B_READ:  state_nx = B_WRITE;
			B_WRITE: if (res_free) state_nx = B_IDLE;
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		clr_busy = (state_q == B_CLEAR);
		job_ready = (state_q == B_IDLE);
		mem_re = (state_q == B_READ) && in_store;
		load_res = (state_q == B_WRITE) && res_free;
		mem_we = clr_busy || (load_res && in_store);
		wr_addr = clr_busy ? clr_q : addr[SAW-1:0];
		wr_data = clr_busy ? '0 : new_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (clr_busy) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				c_re_q <= job.c_re;
				c_im_q <= job.c_im;
				row_q <= job.row;
				col_q <= job.col;
				lim_q <= CW'(lim_cl);
				cnt_q <= '0;
				x_q <= '0;
				y_q <= '0;
			end
			B_MUL: begin
				xx_q <= WIDE_W'(p_xx >>> FRAC_BITS);
				yy_q <= WIDE_W'(p_yy >>> FRAC_BITS);
				xy_q <= FIX_W'(p_xy >>> (FRAC_BITS - 1));
			end
			B_ADD: begin
				if (!escape) begin
					x_q <= FIX_W'(xx_q - yy_q + WIDE_W'(c_re_q));
					y_q <= xy_q + c_im_q;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			B_CLEAR, B_READ, B_WRITE: begin
			end
			default: begin
			end
		endcase
		if (load_res) begin
			res_inside_q <= limit_hit;
			res_iter_q <= ITER_W'(cnt_q);
			res_addr_q <= ADDR_W'(addr);
			res_byte_q <= in_store ? new_byte : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_q <= mem[addr[SAW-1:0]];
		end
	end

	assign res.valid = res_valid_q;
	assign res.inside_res = res_inside_q;
	assign res.iterations_done = res_iter_q;
	assign res.byte_address = res_addr_q;
	assign res.byte_value = res_byte_q;

endmodule

// ===== src/mandelbrot_escape_pixel_plotter.sv =====
// channel  dir  handshake     payload
// pix      in   valid/ready   pixel_row[5:0], pixel_col[5:0]
// res      out  valid/ready   inside_res, iterations_done[5:0], byte_address[8:0],
//                             byte_value[7:0]
// cfg      in   valid/ready   index[1:0] (0 limit, 1 width, 2 height), data[7:0]
//
// Front: a shared restoring divider maps a pixel to c, real part first and then imaginary part;
// a new pixel is taken only once the last one has been pushed to the queue.
// Back: each escape iteration is a multiply step, then an add/compare step; a transaction
// also takes the job while idle, makes a final check, then reads and writes the frame byte.
// A 2-entry queue lets the front map the next pixel while the back iterates.
// After reset the frame store is zeroed, all PAGE_COUNT*DISPLAY_COLUMNS bytes (384 by default);
// pix is not taken until then. cfg is always ready. res holds until taken.
module mandelbrot_escape_pixel_plotter #(
	parameter int DISPLAY_COLUMNS = 64,
	parameter int PAGE_COUNT = 6,
	parameter int MAX_ITERATIONS = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	mep_pix_if.sink   pix,
	mep_res_if.source res,
	mep_cfg_if.sink   cfg
);
	import mep_pkg::*;

	logic [LIMIT_W-1:0]  iteration_limit_q;
	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;

	logic clr_busy;
	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic job_valid;
	logic job_ready;
	job_t job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iteration_limit_q <= LIMIT_RESET;
			image_width_q <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ITER_LIMIT:   iteration_limit_q <= cfg.data[LIMIT_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q <= cfg.data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg.data[HEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mep_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.clr_busy     (clr_busy),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	mep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (job_valid),
		.pop_ready  (job_ready),
		.pop_data   (job)
	);

	mep_back #(
		.DISPLAY_COLUMNS (DISPLAY_COLUMNS),
		.PAGE_COUNT      (PAGE_COUNT),
		.MAX_ITERATIONS  (MAX_ITERATIONS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.iteration_limit (iteration_limit_q),
		.job_valid       (job_valid),
		.job_ready       (job_ready),
		.job             (job),
		.clr_busy        (clr_busy),
		.res             (res)
	);

endmodule
